### rtl/tfr_pkg.sv
// Shared types, constants and the bytewise CRC-32 step for the TLV frame receiver.
package tfr_pkg;

  localparam int MAX_FRAME = 2048;
  // The byte counter must be able to hold MAX_FRAME + 1.
  localparam int CNT_W = $clog2(MAX_FRAME + 2);
  // Width for comparisons of the counter against the declared length plus eight.
  localparam int CMP_W = 18;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [7:0]  LEN_EXT_MASK = 8'h80;
  localparam logic [6:0]  LEN_LOW_MASK = 7'h7F;

  typedef enum logic [2:0] {
    ROLE_HEADER = 3'd0,
    ROLE_TAG    = 3'd1,
    ROLE_LENGTH = 3'd2,
    ROLE_VALUE  = 3'd3,
    ROLE_EXCESS = 3'd4,
    ROLE_ORPHAN = 3'd5
  } tfr_role_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_TOO_LONG   = 3'd2,
    ST_LEN_MISM   = 3'd3,
    ST_CRC_MISM   = 3'd4,
    ST_TLV_OVERRN = 3'd5
  } tfr_status_t;

  typedef struct packed {
    tfr_role_t   role;
    logic [7:0]  tag;
    logic [14:0] tlen;
    logic [14:0] vidx;
    logic        done;
    tfr_status_t status;
    logic [15:0] ftype;
    logic [15:0] plen;
  } tfr_result_t;

  // One byte of the reflected CRC-32, least significant bit first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/tlv_frame_receiver_crc32_unit.sv
// Top level of the TLV frame receiver: input register, parser and result register.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   data_byte, last
//   out      from block out_valid / out_stall byte_role, tlv_tag, tlv_length, value_index,
//                                             frame_done, frame_status, header_type,
//                                             payload_length
//
// One byte is taken per cycle while in_stall is low; its result passes the input and result registers.
// The rate is set by the combinational CRC and TLV update between the two registers.
// Reset (rst, synchronous) empties both registers and returns the frame state to idle.
// A stall on the output holds the result register and, once the input register is
// full, stalls the input in the same cycle; no transaction is lost or repeated.
module tlv_frame_receiver_crc32_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  byte_role,
  output logic [7:0]  tlv_tag,
  output logic [14:0] tlv_length,
  output logic [14:0] value_index,
  output logic        frame_done,
  output logic [2:0]  frame_status,
  output logic [15:0] header_type,
  output logic [15:0] payload_length
);
  import tfr_pkg::*;

  logic        in_reg_valid;
  logic [7:0]  in_reg_byte;
  logic        in_reg_last;
  logic        advance;
  tfr_result_t step_result;
  tfr_result_t out_reg;

  assign advance  = ~out_valid | ~out_stall;
  assign in_stall = in_reg_valid & ~advance;

  tfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (in_reg_valid & advance),
    .data_byte (in_reg_byte),
    .last      (in_reg_last),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_reg_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= in_reg_valid;
      end
    end
    if (in_valid && !in_stall) begin
      in_reg_byte <= data_byte;
      in_reg_last <= last;
    end
    if (in_reg_valid && advance) begin
      out_reg <= step_result;
    end
  end

  assign byte_role      = out_reg.role;
  assign tlv_tag        = out_reg.tag;
  assign tlv_length     = out_reg.tlen;
  assign value_index    = out_reg.vidx;
  assign frame_done     = out_reg.done;
  assign frame_status   = out_reg.status;
  assign header_type    = out_reg.ftype;
  assign payload_length = out_reg.plen;

endmodule

### rtl/tfr_parser.sv
// Frame state, TLV walker and CRC check: labels one byte per step.
module tfr_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last,
  output tfr_pkg::tfr_result_t result
);
  import tfr_pkg::*;

  typedef enum logic [2:0] {
    PH_TAG   = 3'd0,
    PH_LEN0  = 3'd1,
    PH_LEN1  = 3'd2,
    PH_VALUE = 3'd3,
    PH_FAULT = 3'd4
  } phase_t;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      type_reg, type_reg_next;
  logic [15:0]      declared_length, declared_length_next;
  logic [31:0]      running_crc, running_crc_next;
  logic [31:0]      received_crc, received_crc_next;
  phase_t           tlv_phase, tlv_phase_next;
  logic [7:0]       current_tag, current_tag_next;
  logic [6:0]       length_low_bits, length_low_bits_next;
  logic [14:0]      value_remaining, value_remaining_next;
  logic [14:0]      value_offset, value_offset_next;
  logic             tlv_fault, tlv_fault_next;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] dl_ext;
  logic [CMP_W-1:0] crc_index;
  logic [15:0]      left;
  logic [14:0]      new_len;
  logic             new_len_valid;

  always_comb begin
    byte_count_next      = byte_count;
    type_reg_next        = type_reg;
    declared_length_next = declared_length;
    running_crc_next     = running_crc;
    received_crc_next    = received_crc;
    tlv_phase_next       = tlv_phase;
    current_tag_next     = current_tag;
    length_low_bits_next = length_low_bits;
    value_remaining_next = value_remaining;
    value_offset_next    = value_offset;
    tlv_fault_next       = tlv_fault;

    pos_ext       = CMP_W'(byte_count);
    dl_ext        = CMP_W'(declared_length);
    crc_index     = pos_ext - CMP_W'(4) - dl_ext;
    // Payload bytes still to come after this one; only meaningful inside the payload.
    left          = 16'(dl_ext + CMP_W'(3) - pos_ext);
    new_len       = '0;
    new_len_valid = 1'b0;

    result        = '0;
    result.role   = ROLE_EXCESS;
    result.status = ST_OK;

    if (byte_count < CNT_W'(MAX_FRAME)) begin
      if (byte_count < CNT_W'(4)) begin
        result.role = ROLE_HEADER;
        if (!byte_count[1]) begin
          type_reg_next = {type_reg[7:0], data_byte};
        end else begin
          declared_length_next = {declared_length[7:0], data_byte};
        end
        running_crc_next = crc32_byte(running_crc, data_byte);
      end else if (pos_ext < dl_ext + CMP_W'(4)) begin
        running_crc_next = crc32_byte(running_crc, data_byte);
        unique case (tlv_phase)
          PH_TAG: begin
            result.role      = ROLE_TAG;
            result.tag       = data_byte;
            current_tag_next = data_byte;
            if (left == '0) begin
              tlv_fault_next = 1'b1;
              tlv_phase_next = PH_FAULT;
            end else begin
              tlv_phase_next = PH_LEN0;
            end
          end
          PH_LEN0: begin
            result.role = ROLE_LENGTH;
            result.tag  = current_tag;
            if ((data_byte & LEN_EXT_MASK) != '0) begin
              length_low_bits_next = data_byte[6:0] & LEN_LOW_MASK;
              if (left == '0) begin
                tlv_fault_next = 1'b1;
                tlv_phase_next = PH_FAULT;
              end else begin
                tlv_phase_next = PH_LEN1;
              end
            end else begin
              new_len       = {8'd0, data_byte[6:0]};
              new_len_valid = 1'b1;
            end
          end
          PH_LEN1: begin
            result.role   = ROLE_LENGTH;
            result.tag    = current_tag;
            new_len       = {data_byte, length_low_bits};
            new_len_valid = 1'b1;
          end
          PH_VALUE: begin
            result.role          = ROLE_VALUE;
            result.tag           = current_tag;
            result.tlen          = value_offset + value_remaining;
            result.vidx          = value_offset;
            value_offset_next    = value_offset + 15'd1;
            value_remaining_next = value_remaining - 15'd1;
            if (value_remaining_next == '0) begin
              tlv_phase_next = PH_TAG;
            end
          end
          default: begin
            result.role = ROLE_ORPHAN;
          end
        endcase

        // A decoded length either opens a value, is empty, or overruns the payload.
        if (new_len_valid) begin
          if ({1'b0, new_len} > left) begin
            tlv_fault_next = 1'b1;
            tlv_phase_next = PH_FAULT;
          end else if (new_len == '0) begin
            tlv_phase_next = PH_TAG;
          end else begin
            value_remaining_next = new_len;
            value_offset_next    = '0;
            tlv_phase_next       = PH_VALUE;
          end
        end
      end else begin
        result.role = ROLE_EXCESS;
        if (crc_index < CMP_W'(4)) begin
          received_crc_next[{crc_index[1:0], 3'b000} +: 8] =
            received_crc[{crc_index[1:0], 3'b000} +: 8] | data_byte;
        end
      end
      byte_count_next = byte_count + CNT_W'(1);
    end else begin
      byte_count_next = CNT_W'(MAX_FRAME + 1);
    end

    result.ftype = type_reg_next;
    result.plen  = declared_length_next;
    result.done  = last;

    if (last) begin
      if (byte_count_next < CNT_W'(8)) begin
        result.status = ST_TOO_SHORT;
      end else if (byte_count_next > CNT_W'(MAX_FRAME)) begin
        result.status = ST_TOO_LONG;
      end else if (CMP_W'(byte_count_next) != CMP_W'(declared_length_next) + CMP_W'(8)) begin
        result.status = ST_LEN_MISM;
      end else if (~running_crc_next != received_crc_next) begin
        result.status = ST_CRC_MISM;
      end else if (tlv_fault_next) begin
        result.status = ST_TLV_OVERRN;
      end else begin
        result.status = ST_OK;
      end

      // The frame is over: everything starts afresh for the next one.
      byte_count_next      = '0;
      type_reg_next        = '0;
      declared_length_next = '0;
      running_crc_next     = CRC_INIT;
      received_crc_next    = '0;
      tlv_phase_next       = PH_TAG;
      current_tag_next     = '0;
      length_low_bits_next = '0;
      value_remaining_next = '0;
      value_offset_next    = '0;
      tlv_fault_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      type_reg        <= '0;
      declared_length <= '0;
      running_crc     <= CRC_INIT;
      received_crc    <= '0;
      tlv_phase       <= PH_TAG;
      current_tag     <= '0;
      length_low_bits <= '0;
      value_remaining <= '0;
      value_offset    <= '0;
      tlv_fault       <= 1'b0;
    end else if (step) begin
      byte_count      <= byte_count_next;
      type_reg        <= type_reg_next;
      declared_length <= declared_length_next;
      running_crc     <= running_crc_next;
      received_crc    <= received_crc_next;
      tlv_phase       <= tlv_phase_next;
      current_tag     <= current_tag_next;
      length_low_bits <= length_low_bits_next;
      value_remaining <= value_remaining_next;
      value_offset    <= value_offset_next;
      tlv_fault       <= tlv_fault_next;
    end
  end

endmodule
